FILE: rtl/zstg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zstg_pkg
// Shared types, constants and helpers of the zoomed sprite tile generator.
// ----------------------------------------------------------------------------
package zstg_pkg;

  localparam int MAP_DEPTH  = 8192;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int MEM_AW     = MAP_AW + 1;
  localparam int MEM_DEPTH  = 2 * MAP_DEPTH;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // control word bit positions
  localparam int CTRL_PRI_BIT    = 4;
  localparam int CTRL_ENABLE_BIT = 7;
  localparam int CTRL_FLIPX_BIT  = 11;
  localparam int CTRL_FLIPY_BIT  = 15;

  localparam logic [8:0] POS_BIAS   = 9'd16;
  localparam logic [5:0] ZOOM_UNITY = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PALETTE_BANK = 2'd0,
    CFG_PASS_FRONT   = 2'd1,
    CFG_GFX_BASE     = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_ENTRY     = 1'b0,
    OP_MAP_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic [8:0] ox;
    logic [8:0] oy;
    logic [5:0] zx;
    logic [5:0] zy;
    logic [2:0] xsize;
    logic [2:0] ysize;
    logic       flip_x;
    logic       flip_y;
  } geom_t;

  typedef struct packed {
    logic start;
    logic advance;
    logic row_end;
  } walk_ctl_t;

  typedef struct packed {
    logic busy;
    logic issue;
    logic last;
  } seq_stat_t;

  // extra map index step after each row; rows of 3, 5, 6 and 7 tiles are padded
  function automatic logic [2:0] row_pad(input logic [2:0] xsize);
    logic [2:0] pad;
    case (xsize)
      3'd2:    pad = 3'd1;
      3'd4:    pad = 3'd3;
      3'd5:    pad = 3'd2;
      3'd6:    pad = 3'd1;
      default: pad = 3'd0;
    endcase
    return pad;
  endfunction

  // wrap to 9 bits with a bias of 16, then move the bias back out as signed
  function automatic logic signed [9:0] place(input logic [8:0] origin,
                                              input logic [7:0] acc);
    logic [8:0] p;
    p = origin + {2'b00, acc[7:1]} + POS_BIAS;
    return signed'({1'b0, p} - {1'b0, POS_BIAS});
  endfunction

  function automatic logic [5:0] zoom_of(input logic [3:0] field);
    return ZOOM_UNITY - {2'b00, field};
  endfunction

endpackage

FILE: rtl/zstg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zstg_in_if
// Input word channel: map writes and sprite attribute entries.
// ----------------------------------------------------------------------------
interface zstg_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        chip;
  logic [15:0] attr_y_word;
  logic [15:0] attr_x_word;
  logic [15:0] attr_ctrl_word;
  logic [15:0] attr_map_word;
  logic [12:0] map_addr;
  logic [15:0] map_data;

  modport source (
    output valid, operation, chip, attr_y_word, attr_x_word, attr_ctrl_word,
           attr_map_word, map_addr, map_data,
    input  ready
  );
  modport sink (
    input  valid, operation, chip, attr_y_word, attr_x_word, attr_ctrl_word,
           attr_map_word, map_addr, map_data,
    output ready
  );
endinterface

FILE: rtl/zstg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zstg_out_if
// Result word channel: one tile command per word.
// ----------------------------------------------------------------------------
interface zstg_out_if;
  logic              valid;
  logic              ready;
  logic [15:0]       tile_code;
  logic [3:0]        graphics_set;
  logic [5:0]        colour;
  logic              flip_x;
  logic              flip_y;
  logic signed [9:0] screen_x;
  logic signed [9:0] screen_y;
  logic [5:0]        zoom_x;
  logic [5:0]        zoom_y;
  logic              behind_flag;
  logic              last;

  modport source (
    output valid, tile_code, graphics_set, colour, flip_x, flip_y, screen_x,
           screen_y, zoom_x, zoom_y, behind_flag, last,
    input  ready
  );
  modport sink (
    input  valid, tile_code, graphics_set, colour, flip_x, flip_y, screen_x,
           screen_y, zoom_x, zoom_y, behind_flag, last,
    output ready
  );
endinterface

FILE: rtl/zstg_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zstg_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface zstg_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [2:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/zstg_map_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zstg_map_mem
// Tile map store of both chips: one write port, one registered read port.
// ----------------------------------------------------------------------------
module zstg_map_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [zstg_pkg::MEM_AW-1:0] waddr,
  input  logic [15:0]               wdata,
  input  logic                      re,
  input  logic [zstg_pkg::MEM_AW-1:0] raddr,
  output logic [15:0]               rdata
);

  logic [15:0] mem [zstg_pkg::MEM_DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the read word while the result waits
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/zstg_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zstg_pos
// Position unit: zoom step accumulators and the wrap-and-bias adders.
// ----------------------------------------------------------------------------
module zstg_pos (
  input  logic                      clk,
  input  zstg_pkg::walk_ctl_t       ctl,
  input  zstg_pkg::geom_t           geom_in,
  output zstg_pkg::geom_t           geom,
  output logic signed [9:0]         screen_x,
  output logic signed [9:0]         screen_y
);

  zstg_pkg::geom_t geom_r;
  logic [7:0] accx_r, accy_r, accx0_r;
  logic [7:0] accx0_nxt, accy0_nxt;

  // flipped walks start at the far cell and step back
  always_comb begin
    accx0_nxt = geom_in.flip_x ? ({2'b00, geom_in.zx} * {5'd0, geom_in.xsize}) : 8'd0;
    accy0_nxt = geom_in.flip_y ? ({2'b00, geom_in.zy} * {5'd0, geom_in.ysize}) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      geom_r  <= geom_in;
      accx0_r <= accx0_nxt;
      accx_r  <= accx0_nxt;
      accy_r  <= accy0_nxt;
    end else if (ctl.advance) begin
      if (ctl.row_end) begin
        accx_r <= accx0_r;
        accy_r <= geom_r.flip_y ? accy_r - {2'b00, geom_r.zy}
                                : accy_r + {2'b00, geom_r.zy};
      end else begin
        accx_r <= geom_r.flip_x ? accx_r - {2'b00, geom_r.zx}
                                : accx_r + {2'b00, geom_r.zx};
      end
    end
  end

  assign geom     = geom_r;
  assign screen_x = zstg_pkg::place(geom_r.ox, accx_r);
  assign screen_y = zstg_pkg::place(geom_r.oy, accy_r);

endmodule

FILE: rtl/zstg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zstg_seq
// Cell sequencer: walks the grid row by row and steps the map index.
// ----------------------------------------------------------------------------
module zstg_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [2:0]                  xsize,
  input  logic [2:0]                  ysize,
  input  logic                        chip,
  input  logic [zstg_pkg::MAP_AW-1:0] start_idx,
  input  logic                        stage_free,
  output zstg_pkg::walk_ctl_t         ctl,
  output zstg_pkg::seq_stat_t         stat,
  output logic                        rd_en,
  output logic [zstg_pkg::MEM_AW-1:0] rd_addr
);

  zstg_pkg::seq_state_t state_r, state_nxt;
  logic [2:0] col_r, row_r, xsize_r, ysize_r;
  logic [zstg_pkg::MAP_AW-1:0] idx_r;
  logic chip_r;
  logic issue, at_row_end, at_last;

  always_comb begin
    issue      = (state_r == zstg_pkg::SEQ_RUN) && stage_free;
    at_row_end = (col_r == xsize_r);
    at_last    = at_row_end && (row_r == ysize_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zstg_pkg::SEQ_IDLE: begin
        if (go) begin
          state_nxt = zstg_pkg::SEQ_RUN;
        end
      end
      zstg_pkg::SEQ_RUN: begin
        if (issue && at_last) begin
          state_nxt = zstg_pkg::SEQ_IDLE;
        end
      end
      default: state_nxt = zstg_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    stat.busy   = (state_r == zstg_pkg::SEQ_RUN);
    stat.issue  = issue;
    stat.last   = at_last;
    ctl.start   = go;
    ctl.advance = issue;
    ctl.row_end = at_row_end;
    rd_en       = issue;
    rd_addr     = {chip_r, idx_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zstg_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      col_r   <= 3'd0;
      row_r   <= 3'd0;
      idx_r   <= start_idx;
      xsize_r <= xsize;
      ysize_r <= ysize;
      chip_r  <= chip;
    end else if (issue) begin
      if (at_row_end) begin
        col_r <= 3'd0;
        row_r <= row_r + 3'd1;
        idx_r <= idx_r + zstg_pkg::MAP_AW'(1)
                 + zstg_pkg::MAP_AW'(zstg_pkg::row_pad(xsize_r));
      end else begin
        col_r <= col_r + 3'd1;
        idx_r <= idx_r + zstg_pkg::MAP_AW'(1);
      end
    end
  end

endmodule

FILE: rtl/zoom_sprite_tile_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zoom_sprite_tile_generator_top
// Sprite entries in, one zoomed tile command per grid cell out.
// ----------------------------------------------------------------------------
// The first tile command of an entry is issued once the sequencer runs and
//   the result stage is free, and is held in the result stage register.
// Throughput: one command per cycle while the result stage is free, from the
//   cell sequencer and the single map read port; an entry gives (xsize+1)*
//   (ysize+1) commands, 1 to 64. No input is taken while a walk runs.
// Reset: synchronous, active low; registers return to palette bank 0, pass
//   class 0, graphics base 2. The map store is not cleared.
module zoom_sprite_tile_generator_top (
  input logic       clk,
  input logic       rst_n,
  zstg_in_if.sink   in_ch,
  zstg_out_if.source out_ch,
  zstg_cfg_if.sink  cfg_ch
);

  logic [1:0] palette_bank_r;
  logic       pass_front_r;
  logic [2:0] gfx_base_r;

  logic in_fire, is_entry, keep, go, map_we, stage_free;
  zstg_pkg::geom_t     geom_in, geom;
  zstg_pkg::walk_ctl_t ctl;
  zstg_pkg::seq_stat_t stat;
  logic                        rd_en;
  logic [zstg_pkg::MEM_AW-1:0] rd_addr;
  logic [15:0]                 rd_data;
  logic signed [9:0]           pos_x, pos_y;

  // per-entry attributes
  logic [5:0] ent_colour_r;
  logic [3:0] ent_gfx_r;
  logic       ent_behind_r;

  // result stage
  logic              out_valid_r;
  logic [3:0]        gfx_r;
  logic [5:0]        colour_r, zx_r, zy_r;
  logic              flipx_r, flipy_r, behind_r, last_r;
  logic signed [9:0] sx_r, sy_r;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_bank_r <= 2'd0;
      pass_front_r   <= 1'b0;
      gfx_base_r     <= 3'd2;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        zstg_pkg::CFG_PALETTE_BANK: palette_bank_r <= cfg_ch.data[1:0];
        zstg_pkg::CFG_PASS_FRONT:   pass_front_r   <= cfg_ch.data[0];
        zstg_pkg::CFG_GFX_BASE:     gfx_base_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // input decode
  always_comb begin
    in_ch.ready = !stat.busy;
    in_fire     = in_ch.valid && in_ch.ready;
    is_entry    = (in_ch.operation == zstg_pkg::OP_ENTRY);
    keep        = in_ch.attr_ctrl_word[zstg_pkg::CTRL_ENABLE_BIT]
                  && (in_ch.attr_ctrl_word[zstg_pkg::CTRL_PRI_BIT] == pass_front_r);
    go          = in_fire && is_entry && keep;
    map_we      = in_fire && (in_ch.operation == zstg_pkg::OP_MAP_WRITE);
    stage_free  = !out_valid_r || out_ch.ready;

    geom_in.ox     = in_ch.attr_x_word[8:0];
    geom_in.oy     = in_ch.attr_y_word[8:0];
    geom_in.zx     = zstg_pkg::zoom_of(in_ch.attr_x_word[15:12]);
    geom_in.zy     = zstg_pkg::zoom_of(in_ch.attr_y_word[15:12]);
    geom_in.xsize  = in_ch.attr_ctrl_word[10:8];
    geom_in.ysize  = in_ch.attr_ctrl_word[14:12];
    geom_in.flip_x = in_ch.attr_ctrl_word[zstg_pkg::CTRL_FLIPX_BIT];
    geom_in.flip_y = in_ch.attr_ctrl_word[zstg_pkg::CTRL_FLIPY_BIT];
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ent_colour_r <= {palette_bank_r, in_ch.attr_ctrl_word[3:0]};
      ent_gfx_r    <= {1'b0, gfx_base_r} + {3'd0, in_ch.chip};
      ent_behind_r <= !in_ch.attr_ctrl_word[zstg_pkg::CTRL_PRI_BIT];
    end
  end

  zstg_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .xsize      (geom_in.xsize),
    .ysize      (geom_in.ysize),
    .chip       (in_ch.chip),
    .start_idx  (in_ch.attr_map_word[zstg_pkg::MAP_AW-1:0]),
    .stage_free (stage_free),
    .ctl        (ctl),
    .stat       (stat),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  zstg_pos u_pos (
    .clk      (clk),
    .ctl      (ctl),
    .geom_in  (geom_in),
    .geom     (geom),
    .screen_x (pos_x),
    .screen_y (pos_y)
  );

  zstg_map_mem u_map_mem (
    .clk   (clk),
    .we    (map_we),
    .waddr ({in_ch.chip, in_ch.map_addr[zstg_pkg::MAP_AW-1:0]}),
    .wdata (in_ch.map_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // result stage: load on issue, drop valid once the word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.issue) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.issue) begin
      gfx_r    <= ent_gfx_r;
      colour_r <= ent_colour_r;
      flipx_r  <= geom.flip_x;
      flipy_r  <= geom.flip_y;
      sx_r     <= pos_x;
      sy_r     <= pos_y;
      zx_r     <= geom.zx;
      zy_r     <= geom.zy;
      behind_r <= ent_behind_r;
      last_r   <= stat.last;
    end
  end

  always_comb begin
    out_ch.valid        = out_valid_r;
    out_ch.tile_code    = rd_data;
    out_ch.graphics_set = gfx_r;
    out_ch.colour       = colour_r;
    out_ch.flip_x       = flipx_r;
    out_ch.flip_y       = flipy_r;
    out_ch.screen_x     = sx_r;
    out_ch.screen_y     = sy_r;
    out_ch.zoom_x       = zx_r;
    out_ch.zoom_y       = zy_r;
    out_ch.behind_flag  = behind_r;
    out_ch.last         = last_r;
  end

  // a result word only appears after the sequencer issued a cell
  a_valid_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(stat.issue))
    else $error("result word without an issued cell");

  // the final cell returns the sequencer to idle
  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.issue && stat.last) |=> !stat.busy)
    else $error("sequencer still busy after last cell");

  // a dropped entry starts no walk
  a_drop_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_entry && !keep) |=> !stat.busy)
    else $error("dropped entry started a walk");

  // map writes never collide with a cell read
  a_no_write_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    !(map_we && rd_en))
    else $error("map write during a cell read");

endmodule
